// ----- hdl/bnsu_pkg.sv -----
// Shared types and constants for the ternary-weight Boolean network update block.
`default_nettype none
package bnsu_pkg;

	localparam int NODES   = 16;
	localparam int CODE_W  = 2;
	localparam int ROW_W   = NODES * CODE_W;
	localparam int IDX_W   = $clog2(NODES);
	localparam int CNT_W   = $clog2(NODES + 1);
	localparam int CFG_W   = 5;

	localparam logic [CFG_W-1:0] NODE_COUNT_RST = CFG_W'(NODES);

	// Weight codes
	localparam logic [CODE_W-1:0] CODE_PLUS  = 2'b01;
	localparam logic [CODE_W-1:0] CODE_MINUS = 2'b11;

	// Request types
	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_STEP = 1'b1;

	typedef logic [ROW_W-1:0] row_t;
	typedef logic [NODES-1:0] state_t;
	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	// Row write request to the weight store
	typedef struct packed {
		logic we;
		idx_t addr;
		row_t data;
	} wr_req_t;

	// Nodes below the configured count are in use
	function automatic state_t node_mask(input logic [CFG_W-1:0] count);
		state_t m;
		for (int j = 0; j < NODES; j++) begin
			m[j] = (CFG_W'(j) < count);
		end
		return m;
	endfunction

endpackage
`default_nettype wire

// ----- hdl/bnsu_weights.sv -----
// Weight matrix store: one row of ternary codes per target node.
`default_nettype none
module bnsu_weights
	import bnsu_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire wr_req_t wr,
	output row_t         rows [NODES]
);

	row_t rows_q [NODES];

	// Write one row per load transfer; reset clears all edges
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NODES; k++) begin
				rows_q[k] <= '0;
			end
		end else if (wr.we) begin
			rows_q[wr.addr] <= wr.data;
		end
	end

	assign rows = rows_q;

endmodule
`default_nettype wire

// ----- hdl/bnsu_node.sv -----
// Next-value logic for one target node.
`default_nettype none
module bnsu_node
	import bnsu_pkg::*;
(
	input  wire row_t   row,
	input  wire state_t active,
	input  wire state_t self_sel,
	output logic        next_bit
);

	state_t pos;
	state_t neg;
	cnt_t   pos_cnt;
	cnt_t   neg_cnt;
	logic   veto;
	logic   self_on;

	// Decode the weight of each active source
	always_comb begin
		for (int j = 0; j < NODES; j++) begin
			pos[j] = active[j] && (row[CODE_W*j +: CODE_W] == CODE_PLUS);
			neg[j] = active[j] && (row[CODE_W*j +: CODE_W] == CODE_MINUS);
		end
	end

	// Count positive and negative contributions
	always_comb begin
		pos_cnt = '0;
		neg_cnt = '0;
		for (int j = 0; j < NODES; j++) begin
			pos_cnt = pos_cnt + cnt_t'(pos[j]);
			neg_cnt = neg_cnt + cnt_t'(neg[j]);
		end
	end

	// An inhibiting active neighbor forces off; self inhibition only counts
	assign veto    = |(neg & ~self_sel);
	assign self_on = |(active & self_sel);

	assign next_bit = !veto && ((pos_cnt > neg_cnt) || ((pos_cnt == neg_cnt) && self_on));

endmodule
`default_nettype wire

// ----- hdl/boolean_network_state_update.sv -----
// Top level: input register, node update lanes and result register.
// Step path: input register, then result register; an unread result stalls it.
// Loads and steps run back to back at one per cycle; a held result stalls a step.
// A load writes its weight row when it leaves the input register; it gives no result.
// Reset (arst_n low, asynchronous) clears all weights to zero, sets node_count to 16
// and empties both registers.
`default_nettype none
module boolean_network_state_update
	import bnsu_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [CFG_W-1:0] cfg_data,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic             req_type,
	input  wire logic [3:0]       row_index,
	input  wire logic [31:0]      row_codes,
	input  wire logic [15:0]      current_state,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [15:0]           next_state
);

	logic [CFG_W-1:0] node_count_q;
	logic             valid_s1;
	logic             type_s1;
	idx_t             index_s1;
	row_t             codes_s1;
	state_t           state_s1;
	logic             out_valid_q;
	state_t           next_q;
	logic             advance_s1;
	logic             step_done;
	state_t           in_use;
	state_t           active;
	state_t           next_c;
	row_t             rows [NODES];
	wr_req_t          wr;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODE_COUNT_RST;
		end else if (cfg_we) begin
			node_count_q <= cfg_data;
		end
	end

	// A held load always moves on; a held step moves on once the result slot frees
	assign advance_s1 = valid_s1 && ((type_s1 == REQ_LOAD) || !out_valid_q || out_ready);
	assign in_ready   = !valid_s1 || advance_s1;
	assign step_done  = advance_s1 && (type_s1 == REQ_STEP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Capture the payload on an input transfer
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			type_s1  <= req_type;
			index_s1 <= row_index;
			codes_s1 <= row_codes;
			state_s1 <= current_state;
		end
	end

	// Commit a load's row as it leaves the input stage
	assign wr.we   = advance_s1 && (type_s1 == REQ_LOAD);
	assign wr.addr = index_s1;
	assign wr.data = codes_s1;

	bnsu_weights u_weights (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.rows   (rows)
	);

	// Drop nodes beyond the configured count
	assign in_use = node_mask(node_count_q);
	assign active = state_s1 & in_use;

	for (genvar i = 0; i < NODES; i++) begin : g_node
		logic node_bit;

		bnsu_node u_node (
			.row      (rows[i]),
			.active   (active),
			.self_sel (state_t'(1) << i),
			.next_bit (node_bit)
		);

		assign next_c[i] = node_bit && in_use[i];
	end

	// Result register: load on a finished step, release on an output transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step_done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_done) begin
			next_q <= next_c;
		end
	end

	assign out_valid  = out_valid_q;
	assign next_state = next_q;

endmodule
`default_nettype wire
